@@ src/heg_pkg.sv @@
// Shared types and constants for the haptic envelope generator.
`timescale 1ns / 1ps

package heg_pkg;

  localparam int OPCODE_W   = 3;
  localparam int DUR_IN_W   = 16;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PULSE    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FADE_IN  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FADE_OUT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SWELL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAMP = 2'd2;

  localparam logic [LEVEL_W-1:0]  FLOOR_RESET    = 8'd50;
  localparam logic [LEVEL_W-1:0]  FULL_RESET     = 8'd200;
  localparam logic [DUR_IN_W-1:0] MIN_RAMP_RESET = 16'd50;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply_item;
    logic fade_step;
    logic swell_step;
    logic mul_step;
    logic div_step;
    logic put_step;
    logic stop_step;
    logic load_out;
  } heg_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_tick;
    logic fade_on;
    logic fade_end;
    logic swell_on;
    logic swell_end;
    logic div_last;
    logic out_free;
  } heg_stat_t;

endpackage

@@ src/heg_req_if.sv @@
// Command channel: opcode and two durations.
`timescale 1ns / 1ps

interface heg_req_if;
  logic                            valid;
  logic                            ready;
  logic [heg_pkg::OPCODE_W-1:0]    opcode;
  logic [heg_pkg::DUR_IN_W-1:0]    first_ms;
  logic [heg_pkg::DUR_IN_W-1:0]    second_ms;

  modport source (output valid, opcode, first_ms, second_ms, input ready);
  modport sink (input valid, opcode, first_ms, second_ms, output ready);
endinterface

@@ src/heg_rsp_if.sv @@
// Result channel: duty level and status flags.
`timescale 1ns / 1ps

interface heg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [heg_pkg::LEVEL_W-1:0]  duty;
  logic                         duty_written;
  logic                         busy_res;

  modport source (output valid, duty, duty_written, busy_res, input ready);
  modport sink (input valid, duty, duty_written, busy_res, output ready);
endinterface

@@ src/heg_ctrl.sv @@
// Sequencer that walks a tick through fade, swell, stop and result load.
`timescale 1ns / 1ps

module heg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  heg_pkg::heg_stat_t  stat,
  output heg_pkg::heg_ctl_t   ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FADE  = 3'd1;
  localparam logic [2:0] S_SWELL = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;
  localparam logic [2:0] S_STOP  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       on_swell;
  logic       on_swell_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    on_swell_next = on_swell;
    ctl           = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.apply_item = 1'b1;
          state_next     = stat.item_tick ? S_FADE : S_DONE;
        end
      end
      S_FADE: begin
        ctl.fade_step = 1'b1;
        on_swell_next = 1'b0;
        state_next    = (!stat.fade_on || stat.fade_end) ? S_SWELL : S_MUL;
      end
      S_SWELL: begin
        ctl.swell_step = 1'b1;
        on_swell_next  = 1'b1;
        state_next     = (!stat.swell_on || stat.swell_end) ? S_STOP : S_MUL;
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        ctl.put_step = 1'b1;
        state_next   = on_swell ? S_STOP : S_SWELL;
      end
      S_STOP: begin
        ctl.stop_step = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      on_swell <= 1'b0;
    end else begin
      state    <= state_next;
      on_swell <= on_swell_next;
    end
  end

`ifndef ASSERT_OFF
  a_div_to_put: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.div_last) |=> (state == S_PUT))
    else $error("divider did not hand over to the put step");

  a_cmd_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && !stat.item_tick) |=> (state == S_DONE))
    else $error("command item did not go straight to result load");

  a_tick_to_fade: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && stat.item_tick) |=> (state == S_FADE))
    else $error("tick item did not start with the fade step");
`endif

endmodule

@@ src/heg_datapath.sv @@
// Envelope state, configuration registers, serial divider and result register.
`timescale 1ns / 1ps

module heg_datapath #(
  parameter int TIME_BITS     = 32,
  parameter int DURATION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [heg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [heg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [heg_pkg::OPCODE_W-1:0]       opcode,
  input  logic [heg_pkg::DUR_IN_W-1:0]       first_ms,
  input  logic [heg_pkg::DUR_IN_W-1:0]       second_ms,
  input  logic                               rsp_ready,
  output logic                               rsp_valid,
  output logic [heg_pkg::LEVEL_W-1:0]        duty,
  output logic                               duty_written,
  output logic                               busy_res,
  input  heg_pkg::heg_ctl_t                  ctl,
  output heg_pkg::heg_stat_t                 stat
);

  localparam int TB = TIME_BITS;
  localparam int DB = DURATION_BITS;
  // Compare width: holds any time difference and the sum of two durations.
  localparam int CW = (TB > DB) ? TB + 1 : DB + 1;
  localparam int PW = DB + heg_pkg::LEVEL_W;
  localparam logic [31:0] DMAX = (32'd1 << DB) - 32'd1;

  function automatic logic [DB-1:0] sat_dur(input logic [heg_pkg::DUR_IN_W-1:0] v);
    logic [31:0] w;
    w = {16'd0, v};
    return (w > DMAX) ? '1 : w[DB-1:0];
  endfunction

  logic [heg_pkg::LEVEL_W-1:0]  floor_level;
  logic [heg_pkg::LEVEL_W-1:0]  full_level;
  logic [heg_pkg::DUR_IN_W-1:0] min_ramp_ms;

  logic [TB-1:0] clock_ms;
  logic          stop_armed;
  logic [TB-1:0] stop_time;
  logic          fade_on;
  logic          fade_rising;
  logic [TB-1:0] fade_start;
  logic [DB-1:0] fade_length;
  logic [DB-1:0] fade_hold;
  logic          swell_on;
  logic [TB-1:0] swell_start;
  logic [DB-1:0] swell_rise;
  logic [DB-1:0] swell_fall;
  logic [heg_pkg::LEVEL_W-1:0] duty_level;
  logic          wrote;

  // Divider operands and working registers.
  logic [DB-1:0] dv_num;
  logic [DB-1:0] dv_len;
  logic          dv_up;
  logic [PW-1:0] rem;
  logic [heg_pkg::LEVEL_W-1:0] quo;
  logic [2:0]    div_cnt;

  logic [heg_pkg::LEVEL_W-1:0] lo;
  logic [heg_pkg::LEVEL_W-1:0] span;
  logic [DB-1:0] a_sat;
  logic [DB-1:0] b_sat;
  logic [DB-1:0] m_sat;
  logic [DB-1:0] a_ramp;
  logic [DB-1:0] b_ramp;
  logic [TB-1:0] fade_el_t;
  logic [TB-1:0] swell_el_t;
  logic [TB-1:0] stop_diff;
  logic [CW-1:0] fade_el;
  logic [CW-1:0] swell_el;
  logic [CW-1:0] swell_total;
  logic [CW-1:0] swell_fall_el;
  logic          fade_end;
  logic          swell_end;
  logic          swell_up;
  logic [PW-1:0] trial;
  logic          trial_fits;

  assign lo     = (floor_level > full_level) ? full_level : floor_level;
  assign span   = full_level - lo;
  assign a_sat  = sat_dur(first_ms);
  assign b_sat  = sat_dur(second_ms);
  assign m_sat  = sat_dur(min_ramp_ms);
  assign a_ramp = (a_sat < m_sat) ? m_sat : a_sat;
  assign b_ramp = (b_sat < m_sat) ? m_sat : b_sat;

  assign fade_el_t     = clock_ms - fade_start;
  assign swell_el_t    = clock_ms - swell_start;
  assign stop_diff     = clock_ms - stop_time;
  assign fade_el       = CW'(fade_el_t);
  assign swell_el      = CW'(swell_el_t);
  assign swell_total   = CW'(swell_rise) + CW'(swell_fall);
  assign swell_fall_el = swell_el - CW'(swell_rise);
  assign fade_end      = (fade_el >= CW'(fade_length));
  assign swell_end     = (swell_el >= swell_total);
  assign swell_up      = (swell_el < CW'(swell_rise));

  assign trial      = PW'(dv_len) << div_cnt;
  assign trial_fits = (rem >= trial);

  always_comb begin
    stat.item_tick = (opcode == heg_pkg::OP_TICK);
    stat.fade_on   = fade_on;
    stat.fade_end  = fade_end;
    stat.swell_on  = swell_on;
    stat.swell_end = swell_end;
    stat.div_last  = (div_cnt == 3'd0);
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_level <= heg_pkg::FLOOR_RESET;
      full_level  <= heg_pkg::FULL_RESET;
      min_ramp_ms <= heg_pkg::MIN_RAMP_RESET;
      clock_ms    <= '0;
      stop_armed  <= 1'b0;
      stop_time   <= '0;
      fade_on     <= 1'b0;
      fade_rising <= 1'b0;
      fade_start  <= '0;
      fade_length <= '0;
      fade_hold   <= '0;
      swell_on    <= 1'b0;
      swell_start <= '0;
      swell_rise  <= '0;
      swell_fall  <= '0;
      duty_level  <= '0;
      wrote       <= 1'b0;
      dv_num      <= '0;
      dv_len      <= '0;
      dv_up       <= 1'b0;
      rem         <= '0;
      quo         <= '0;
      div_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          heg_pkg::CFG_FLOOR:    floor_level <= cfg_data[heg_pkg::LEVEL_W-1:0];
          heg_pkg::CFG_FULL:     full_level  <= cfg_data[heg_pkg::LEVEL_W-1:0];
          heg_pkg::CFG_MIN_RAMP: min_ramp_ms <= cfg_data;
          default: ;
        endcase
      end

      if (ctl.apply_item) begin
        wrote <= 1'b0;
        unique case (opcode) inside
          heg_pkg::OP_TICK: begin
            clock_ms <= clock_ms + TB'(1);
          end
          heg_pkg::OP_PULSE: begin
            duty_level <= full_level;
            wrote      <= 1'b1;
            stop_armed <= 1'b1;
            stop_time  <= clock_ms + TB'(a_sat);
          end
          heg_pkg::OP_FADE_IN, heg_pkg::OP_FADE_OUT: begin
            fade_on     <= 1'b1;
            fade_rising <= (opcode == heg_pkg::OP_FADE_IN);
            fade_length <= a_ramp;
            fade_hold   <= (opcode == heg_pkg::OP_FADE_IN) ? b_sat : '0;
            fade_start  <= clock_ms;
          end
          heg_pkg::OP_SWELL: begin
            swell_on    <= 1'b1;
            swell_rise  <= a_ramp;
            swell_fall  <= b_ramp;
            swell_start <= clock_ms;
            duty_level  <= lo;
            wrote       <= 1'b1;
          end
          default: ;
        endcase
      end

      if (ctl.fade_step && fade_on) begin
        if (fade_end) begin
          wrote      <= 1'b1;
          fade_on    <= 1'b0;
          stop_armed <= 1'b1;
          if (fade_rising) begin
            duty_level <= full_level;
            stop_time  <= clock_ms + TB'(fade_hold);
          end else begin
            duty_level <= lo;
            stop_time  <= clock_ms;
          end
        end else begin
          dv_num <= fade_el[DB-1:0];
          dv_len <= fade_length;
          dv_up  <= fade_rising;
        end
      end

      if (ctl.swell_step && swell_on) begin
        if (swell_end) begin
          duty_level <= lo;
          wrote      <= 1'b1;
          swell_on   <= 1'b0;
          stop_armed <= 1'b1;
          stop_time  <= clock_ms;
        end else if (swell_up) begin
          dv_num <= swell_el[DB-1:0];
          dv_len <= swell_rise;
          dv_up  <= 1'b1;
        end else begin
          dv_num <= swell_fall_el[DB-1:0];
          dv_len <= swell_fall;
          dv_up  <= 1'b0;
        end
      end

      if (ctl.mul_step) begin
        rem     <= PW'(dv_num) * PW'(span);
        quo     <= '0;
        div_cnt <= 3'd7;
      end

      // Restoring division, one quotient bit per cycle; the quotient stays below span, or is zero when span is zero.
      if (ctl.div_step) begin
        if (trial_fits) begin
          rem          <= rem - trial;
          quo[div_cnt] <= 1'b1;
        end
        div_cnt <= div_cnt - 3'd1;
      end

      if (ctl.put_step) begin
        duty_level <= dv_up ? (lo + quo) : (full_level - quo);
        wrote      <= 1'b1;
      end

      if (ctl.stop_step && stop_armed && !stop_diff[TB-1]) begin
        duty_level <= '0;
        wrote      <= 1'b1;
        stop_armed <= 1'b0;
        stop_time  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid    <= 1'b0;
      duty         <= '0;
      duty_written <= 1'b0;
      busy_res     <= 1'b0;
    end else if (ctl.load_out) begin
      rsp_valid    <= 1'b1;
      duty         <= duty_level;
      duty_written <= wrote;
      busy_res     <= stop_armed || fade_on || swell_on;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_quo_below_span: assert property (@(posedge clk) disable iff (rst)
    ctl.put_step |-> ((quo < span) || (span == '0)))
    else $error("ramp quotient reached the level span");

  a_stop_clears_duty: assert property (@(posedge clk) disable iff (rst)
    $fell(stop_armed) |-> (duty_level == '0))
    else $error("stop fired without clearing the duty level");
`endif

endmodule

@@ src/haptic_envelope_generator.sv @@
// Top level of the haptic envelope generator.
`timescale 1ns / 1ps

// Takes pulse, fade, swell and 1 ms tick items on req and returns one result item on rsp
// per input item: the duty level after the step, whether the step wrote it, and whether
// a stop, fade or swell is still pending. A pulse, fade or swell item goes straight from
// acceptance to the result load. A tick steps through fade, swell, stop and result load;
// each fade or swell that is mid-ramp adds a multiply step, the restoring divider, which
// produces one quotient bit per cycle and is shared between fade and swell, and a put
// step. The result register frees the input side as soon as it is loaded; a stalled rsp
// holds the next item in its final step. The user must write the configuration registers
// (floor_level, full_level, min_ramp_ms) with cfg_we, cfg_index and cfg_data only while
// the block is idle; the block itself does not enforce this.
module haptic_envelope_generator #(
  parameter int TIME_BITS     = 32,
  parameter int DURATION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [heg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [heg_pkg::CFG_DATA_W-1:0]  cfg_data,
  heg_req_if.sink                         req,
  heg_rsp_if.source                       rsp
);

  heg_pkg::heg_ctl_t  ctl;
  heg_pkg::heg_stat_t stat;

  heg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  heg_datapath #(
    .TIME_BITS     (TIME_BITS),
    .DURATION_BITS (DURATION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (req.opcode),
    .first_ms     (req.first_ms),
    .second_ms    (req.second_ms),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .duty         (rsp.duty),
    .duty_written (rsp.duty_written),
    .busy_res     (rsp.busy_res),
    .ctl          (ctl),
    .stat         (stat)
  );

endmodule
